[rtl/fmprf_pkg.sv]
// fmprf_pkg: shared sizes, codes and record types for the first-match rule filter
// used by fmprf_rule_mem and first_match_packet_rule_filter; no dependencies
`timescale 1ns / 1ps

package fmprf_pkg;

    // table geometry
    localparam int RULE_DEPTH = 64;
    localparam int IDX_W      = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RULE_DEPTH + 1);
    localparam int MATCH_W    = 6;

    // stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 16;

    // operation codes carried in s_axis_tuser
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    // protocol codes
    localparam logic [1:0] PROTO_ANY  = 2'd0;
    localparam logic [1:0] PROTO_RSVD = 2'd3;

    // port value that matches any port
    localparam logic [15:0] PORT_ANY = 16'd0;

    // one stored rule
    typedef struct packed {
        logic        src_any;
        logic [31:0] src_addr;
        logic        dst_any;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [1:0]  proto;
        logic        action;
    } rule_t;

    // packet fields compared against a rule
    typedef struct packed {
        logic [1:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } key_t;

    // compare status of the rule just read
    typedef struct packed {
        logic hit;
        logic action;
    } match_t;

    // result transaction, allow in the lowest bit
    typedef struct packed {
        logic               table_full;
        logic [MATCH_W-1:0] match_index;
        logic               matched;
        logic               allow;
    } res_t;

endpackage

[rtl/first_match_packet_rule_filter.sv]
// first_match_packet_rule_filter: rule table append and first-match packet check
// depends on fmprf_pkg and fmprf_rule_mem
//
//   channel   dir   signals                                   carries
//   s_axis    in    tvalid tready tdata[103:0] tuser[0:0]     append rule / check packet
//   m_axis    out   tvalid tready tdata[15:0]                 one result per input
//
// one transaction at a time; an append, or a check on an empty table, goes straight
// to the result stage, a check first walks the stored rules from index 0 to the first hit
// or the last rule (at most RULE_DEPTH), through the single read port of the rule memory stepping
// one rule a cycle. the result waits in an output register, and the next transaction
// is taken while it waits. rst_n clears the rule count and control; rule contents are
// not cleared and only entries below the count are ever read.
`timescale 1ns / 1ps

module first_match_packet_rule_filter
(
    input  logic                                clk,
    input  logic                                rst_n,
    // fields from bit 0: proto_code[1:0], src_addr[33:2], src_any[34],
    // dst_addr[66:35], dst_any[67], src_port[83:68], dst_port[99:84],
    // rule_allow[100], zero pad[103:101]
    input  logic [fmprf_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // fields from bit 0: opcode[0]
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0: allow[0], matched[1], match_index[7:2],
    // table_full[8], zero pad[15:9]
    output logic [fmprf_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [fmprf_pkg::CNT_W-1:0] count_reg, count_next;
    logic [fmprf_pkg::IDX_W-1:0] idx_reg, idx_next;
    fmprf_pkg::key_t             key_reg, key_next;
    fmprf_pkg::res_t             res_reg, res_next;
    fmprf_pkg::res_t             out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;

    logic                        accept;
    fmprf_pkg::key_t             in_key;
    fmprf_pkg::rule_t            in_rule;
    logic                        wr_en;
    logic                        rd_en;
    logic [fmprf_pkg::IDX_W-1:0] rd_addr;
    fmprf_pkg::match_t           match;
    logic                        last_rule;

    // unpack the input transaction
    always_comb
    begin
        in_key.proto    = s_axis_tdata[1:0];
        in_key.src_addr = s_axis_tdata[33:2];
        in_key.dst_addr = s_axis_tdata[66:35];
        in_key.src_port = s_axis_tdata[83:68];
        in_key.dst_port = s_axis_tdata[99:84];

        in_rule.src_any  = s_axis_tdata[34];
        in_rule.src_addr = s_axis_tdata[33:2];
        in_rule.dst_any  = s_axis_tdata[67];
        in_rule.dst_addr = s_axis_tdata[66:35];
        in_rule.src_port = s_axis_tdata[83:68];
        in_rule.dst_port = s_axis_tdata[99:84];
        in_rule.proto    = (s_axis_tdata[1:0] == fmprf_pkg::PROTO_RSVD)
                           ? fmprf_pkg::PROTO_ANY : s_axis_tdata[1:0];
        in_rule.action   = s_axis_tdata[100];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign last_rule     = ((fmprf_pkg::CNT_W'(idx_reg) + fmprf_pkg::CNT_W'(1)) == count_reg);

    // rule table
    fmprf_rule_mem u_rule_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[fmprf_pkg::IDX_W-1:0]),
        .wr_rule (in_rule),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .key     (key_reg),
        .match   (match)
    );

    // sequencer: append, rule walk and result hand-off
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        // output register drains on its own handshake
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = in_key;
                    res_next = '0;
                    if (s_axis_tuser == fmprf_pkg::OP_APPEND)
                    begin
                        state_next = ST_DONE;
                        if (count_reg == fmprf_pkg::CNT_W'(fmprf_pkg::RULE_DEPTH))
                        begin
                            res_next.table_full = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + fmprf_pkg::CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.allow = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (match.hit)
                begin
                    res_next.allow       = match.action;
                    res_next.matched     = 1'b1;
                    res_next.match_index = fmprf_pkg::MATCH_W'(idx_reg);
                    state_next           = ST_DONE;
                end
                else if (last_rule)
                begin
                    res_next.allow = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + fmprf_pkg::IDX_W'(1);
                    idx_next = idx_reg + fmprf_pkg::IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(fmprf_pkg::M_TDATA_W - $bits(fmprf_pkg::res_t))'(0), out_reg};

endmodule

[rtl/fmprf_rule_mem.sv]
// fmprf_rule_mem: rule table memory with registered read and rule/packet compare
// depends on fmprf_pkg
`timescale 1ns / 1ps

module fmprf_rule_mem
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [fmprf_pkg::IDX_W-1:0] wr_addr,
    input  fmprf_pkg::rule_t        wr_rule,
    input  logic                    rd_en,
    input  logic [fmprf_pkg::IDX_W-1:0] rd_addr,
    input  fmprf_pkg::key_t         key,
    output fmprf_pkg::match_t       match
);

    fmprf_pkg::rule_t rule_mem [fmprf_pkg::RULE_DEPTH];
    fmprf_pkg::rule_t rd_rule_reg;

    logic proto_ok;
    logic src_ok;
    logic dst_ok;
    logic sport_ok;
    logic dport_ok;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_mem[wr_addr] <= wr_rule;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_rule_reg <= rule_mem[rd_addr];
        end
    end

    // field compares of the rule read last cycle
    always_comb
    begin
        proto_ok = (rd_rule_reg.proto == fmprf_pkg::PROTO_ANY) || (rd_rule_reg.proto == key.proto);
        src_ok   = rd_rule_reg.src_any || (rd_rule_reg.src_addr == key.src_addr);
        dst_ok   = rd_rule_reg.dst_any || (rd_rule_reg.dst_addr == key.dst_addr);
        sport_ok = (rd_rule_reg.src_port == fmprf_pkg::PORT_ANY)
                   || (rd_rule_reg.src_port == key.src_port);
        dport_ok = (rd_rule_reg.dst_port == fmprf_pkg::PORT_ANY)
                   || (rd_rule_reg.dst_port == key.dst_port);
        match.hit    = proto_ok && src_ok && dst_ok && sport_ok && dport_ok;
        match.action = rd_rule_reg.action;
    end

endmodule
